[src/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned OutCountW  = 5;
  localparam int unsigned OutDataW   = 72;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [KeyW-1:0] KEY_NONE = '1;

  // operation broadcast to every cell in the row
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic signed [KeyW-1:0] key;
  } cell_op_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic                   valid;
    logic                   gt;
    logic signed [KeyW-1:0] key;
  } cell_link_t;

endpackage

[src/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_op_t   op_i,
  input  spq_pkg::cell_link_t prev_i,
  input  spq_pkg::cell_link_t next_i,
  output spq_pkg::cell_link_t link_o
);

  logic                           valid_q, valid_d;
  logic signed [spq_pkg::KeyW-1:0] key_q, key_d;
  logic                           gt;

  assign gt = valid_q && (key_q > op_i.key);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (op_i.rem) begin
      // shift toward the head
      valid_d = next_i.valid;
      key_d   = next_i.key;
    end else if (op_i.ins) begin
      if (prev_i.gt) begin
        valid_d = 1'b1;
        key_d   = prev_i.key;
      end else if (gt || (!valid_q && prev_i.valid)) begin
        valid_d = 1'b1;
        key_d   = op_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.gt    = gt;
  assign link_o.key   = key_q;

endmodule

[src/sorted_priority_queue_top.sv]
`timescale 1ns / 1ps
// Bounded min-priority queue of signed 32-bit keys, kept sorted in a row of
// cells (one key per cell, head cell holds the smallest key).
// Input channel s_axis: tuser selects insert (0) or remove (1), tdata carries
// the key for an insert. Output channel m_axis: one result item per input
// item with the removed key, a status code, the count, an empty flag and the
// front key after the operation.
// Latency: the result item is valid the cycle after its input is accepted.
// Throughput: one item per cycle while the receiver takes each result. Every
// cell compares its key with the incoming key and picks its own key, its
// neighbor's or the new key in the same cycle, so the whole row updates together.
// Equal keys leave in arrival order. A remove on an empty queue returns -1
// with status 1; an insert on a full queue is dropped with status 2.
// Reset empties the queue and drops the output valid.
// When the receiver stalls, the result is held and s_axis_tready drops until
// the result is taken; a new item is accepted in the same cycle the held
// result leaves.
module sorted_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] key_in
  input  logic        s_axis_tuser,  // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] removed_key, [33:32] status, [38:34] entry_count,
  // [39] queue_empty, [71:40] front_key
  output logic [spq_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned Depth = spq_pkg::QueueDepth;

  spq_pkg::cell_link_t links [Depth];
  spq_pkg::cell_op_t   op;

  logic                            accept;
  logic                            full, empty;
  logic [spq_pkg::CountW-1:0]      count_q, count_d;
  logic                            out_valid_q;
  logic signed [spq_pkg::KeyW-1:0] removed_q, removed_d;
  logic [1:0]                      status_q, status_d;
  logic signed [spq_pkg::KeyW-1:0] front_key;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == spq_pkg::CountW'(Depth));
  assign empty         = (count_q == '0);

  assign op.ins = accept && (s_axis_tuser == spq_pkg::KIND_INSERT) && !full;
  assign op.rem = accept && (s_axis_tuser == spq_pkg::KIND_REMOVE) && !empty;
  assign op.key = s_axis_tdata;

  always_comb begin
    count_d   = count_q;
    removed_d = spq_pkg::KEY_NONE;
    status_d  = spq_pkg::ST_OK;
    if (s_axis_tuser == spq_pkg::KIND_INSERT) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        count_d   = count_q - 1'b1;
        removed_d = links[0].key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

  // head link: always valid, never greater, so the head cell takes a new key
  // into an empty queue
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::cell_link_t prev_link, next_link;
    if (i == 0) begin : g_head
      assign prev_link = '{valid: 1'b1, gt: 1'b0, key: '0};
    end else begin : g_mid
      assign prev_link = links[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign next_link = '0;
    end else begin : g_body
      assign next_link = links[i+1];
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op),
      .prev_i (prev_link),
      .next_i (next_link),
      .link_o (links[i])
    );
  end

  // state only moves on accept, so it matches the held result
  assign front_key = links[0].valid ? links[0].key : spq_pkg::KEY_NONE;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {front_key, empty, spq_pkg::OutCountW'(count_q), status_q, removed_q};

endmodule

[src/spq_checker.sv]
`timescale 1ns / 1ps

module spq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [spq_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [31:0] removed_key, front_key;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  logic        queue_empty;

  assign removed_key = m_axis_tdata[31:0];
  assign status      = m_axis_tdata[33:32];
  assign entry_count = m_axis_tdata[38:34];
  assign queue_empty = m_axis_tdata[39];
  assign front_key   = m_axis_tdata[71:40];

  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (queue_empty == (entry_count == 5'd0)))
    else $error("empty flag disagrees with count");

  a_empty_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && queue_empty) |-> (front_key == 32'hFFFF_FFFF))
    else $error("front key not -1 on empty queue");

  a_fail_removed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status != spq_pkg::ST_OK) |-> (removed_key == 32'hFFFF_FFFF))
    else $error("failed operation returned a key");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no result after accepted item");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int NumItems = 1750;
  localparam int NumRows  = 25;
  localparam int HoldAt   = 300;
  localparam int HoldLen  = 200;

  // m_axis_tdata layout, highest field first
  typedef struct packed {
    logic [KeyW-1:0]      front;
    logic                 empty;
    logic [OutCountW-1:0] count;
    logic [1:0]           status;
    logic [KeyW-1:0]      removed;
  } result_t;

  typedef struct packed {
    logic            kind;
    logic [KeyW-1:0] key;
    logic            fixed_exp;
    result_t         want;
  } row_t;

  // result fields in the order front, empty, count, status, removed
  localparam row_t DIR_ROWS [NumRows] = '{
    '{KIND_REMOVE, 32'd0, 1'b1, '{KEY_NONE, 1'b1, 5'd0, ST_EMPTY, KEY_NONE}},
    '{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b0, 5'd1, ST_OK, KEY_NONE}},
    '{KIND_INSERT, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0, 5'd2, ST_OK, KEY_NONE}},
    '{KIND_REMOVE, 32'd0, 1'b1, '{32'h7FFF_FFFF, 1'b0, 5'd1, ST_OK, 32'h8000_0000}},
    '{KIND_REMOVE, 32'd0, 1'b1, '{KEY_NONE, 1'b1, 5'd0, ST_OK, 32'h7FFF_FFFF}},
    '{KIND_REMOVE, 32'd0, 1'b1, '{KEY_NONE, 1'b1, 5'd0, ST_EMPTY, KEY_NONE}},
    // a stored -1 must still read as a non-empty queue
    '{KIND_INSERT, 32'hFFFF_FFFF, 1'b1, '{KEY_NONE, 1'b0, 5'd1, ST_OK, KEY_NONE}},
    '{KIND_INSERT, 32'd0, 1'b0, '0},
    '{KIND_INSERT, 32'd5, 1'b0, '0},
    '{KIND_INSERT, 32'd5, 1'b0, '0},
    '{KIND_INSERT, 32'h5555_5555, 1'b0, '0},
    '{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
    '{KIND_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
    '{KIND_INSERT, 32'd1, 1'b0, '0},
    '{KIND_INSERT, 32'd7, 1'b0, '0},
    '{KIND_INSERT, 32'd3, 1'b0, '0},
    '{KIND_INSERT, 32'h8000_0000, 1'b0, '0},
    '{KIND_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
    '{KIND_INSERT, 32'd100, 1'b0, '0},
    '{KIND_INSERT, 32'hFFFF_FF9C, 1'b0, '0},
    '{KIND_INSERT, 32'd2, 1'b0, '0},
    '{KIND_INSERT, 32'd5, 1'b0, '0},
    // queue is full here
    '{KIND_INSERT, 32'd9, 1'b1, '{32'h8000_0000, 1'b0, 5'd16, ST_FULL, KEY_NONE}},
    '{KIND_REMOVE, 32'd0, 1'b1, '{32'hAAAA_AAAA, 1'b0, 5'd15, ST_OK, 32'h8000_0000}},
    '{KIND_REMOVE, 32'h1234_5678, 1'b0, '0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = KIND_INSERT;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic signed [KeyW-1:0] shadow_keys [QueueDepth];
  int                     shadow_count = 0;
  result_t                pending_results [$];
  int                     mismatch_count = 0;

  sorted_priority_queue_top u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // apply one operation to the shadow queue and return the result it gives
  function automatic result_t queue_apply(input logic kind, input logic signed [KeyW-1:0] key);
    result_t r;
    int      pos;
    int      i;
    r         = '0;
    r.removed = KEY_NONE;
    r.status  = ST_OK;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= QueueDepth) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // equal keys go behind the stored ones
        while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
        for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = key;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed = shadow_keys[0];
      for (i = 1; i < shadow_count; i++) shadow_keys[i-1] = shadow_keys[i];
      shadow_count--;
    end
    r.count = OutCountW'(shadow_count);
    r.empty = (shadow_count == 0);
    r.front = (shadow_count == 0) ? KEY_NONE : shadow_keys[0];
    return r;
  endfunction

  // hold valid low for the given gap, then offer one item and record its result once accepted
  task automatic offer(input logic kind, input logic [KeyW-1:0] key, input int gap,
                       input logic use_want, input result_t want);
    result_t predicted;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = queue_apply(kind, key);
    pending_results.push_back(use_want ? want : predicted);
  endtask

  task automatic check_field(input string name, input logic [KeyW-1:0] want,
                             input logic [KeyW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : stimulus
    int              sent;
    int              gap;
    int              ins_pct;
    int              burst_len;
    logic            no_gap;
    logic            kind;
    logic [KeyW-1:0] key;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      offer(DIR_ROWS[r].kind, DIR_ROWS[r].key, $urandom_range(0, 19),
            DIR_ROWS[r].fixed_exp, DIR_ROWS[r].want);
    end

    // drop valid and hold until every result is back
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    sent = NumRows;
    while (sent < NumItems) begin
      burst_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      no_gap = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        kind = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
        case ($urandom_range(0, 3))
          // narrow range for plenty of equal keys
          0: key = 32'($urandom_range(0, 8)) - 32'd4;
          1: begin
            case ($urandom_range(0, 4))
              0:       key = 32'h8000_0000;
              1:       key = 32'h7FFF_FFFF;
              2:       key = '1;
              3:       key = '0;
              default: key = 32'd1;
            endcase
          end
          default: key = $urandom;
        endcase
        gap = no_gap ? 0 : $urandom_range(0, 19);
        offer(kind, key, gap, 1'b0, '0);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : drain
    int   taken;
    int   stall;
    logic calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 19);
      // one long hold so the block fills up and backs up its input
      if (taken == HoldAt) stall = HoldLen;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("removed_key", want.removed, got.removed);
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("entry_count", 32'(want.count), 32'(got.count));
        check_field("queue_empty", 32'(want.empty), 32'(got.empty));
        check_field("front_key", want.front, got.front);
      end
    end
  end

endmodule

[filelist.f]
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
src/spq_checker.sv
tb/sv/tb_top.sv
